>>> hdl/content_type_body_sniffer_macros.svh
// assertion helpers for the sniffer top level
`ifndef CONTENT_TYPE_BODY_SNIFFER_MACROS_SVH
`define CONTENT_TYPE_BODY_SNIFFER_MACROS_SVH

// consequent checked in the same cycle
`define CTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cts_pkg.sv
package cts_pkg;

    typedef enum logic [1:0] {
        CLS_HTML  = 2'd0,
        CLS_TEXT  = 2'd1,
        CLS_UNSUP = 2'd2
    } t_type_class;

    typedef enum logic [1:0] {
        EXP_ANY     = 2'd0,
        EXP_JSON    = 2'd1,
        EXP_ARCHIVE = 2'd2,
        EXP_OTHER   = 2'd3
    } t_expect;

    // per-beat control from the top level to a matcher
    typedef struct packed {
        logic       step;
        logic       clear;
        logic [7:0] char_in;
    } t_step;

    localparam int TYPE_PATS = 6;
    localparam int MARK_PATS = 3;
    localparam int TYPE_STR_LEN = 21;
    localparam int MARK_STR_LEN = 9;

    // left aligned, zero padded
    localparam logic [8*TYPE_STR_LEN-1:0] TYPE_STR [TYPE_PATS] = '{
        {"text/html", {12{8'h00}}},
        "application/xhtml+xml",
        {"text/", {16{8'h00}}},
        {"application/", {9{8'h00}}},
        {"application/json", {5{8'h00}}},
        {"application/xml", {6{8'h00}}}
    };
    localparam logic [4:0] TYPE_LEN [TYPE_PATS] = '{5'd9, 5'd21, 5'd5, 5'd12, 5'd16, 5'd15};
    localparam logic [TYPE_PATS-1:0] TYPE_EXACT = 6'b110011;

    localparam logic [8*MARK_STR_LEN-1:0] MARK_STR [MARK_PATS] = '{
        {"<html", {4{8'h00}}},
        "<!doctype",
        {"<?xml", {4{8'h00}}}
    };
    localparam logic [3:0] MARK_LEN [MARK_PATS] = '{4'd5, 4'd9, 4'd5};

    localparam logic [39:0] SUFFIX_JSON = 40'h2B6A736F6E;
    localparam logic [31:0] SUFFIX_XML  = 32'h2B786D6C;

    function automatic logic [7:0] lower8(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = c;
            if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
            return r;
        end
    endfunction

    function automatic logic [7:0] type_pat_char(input logic [2:0] idx, input logic [4:0] pos);
        logic [7:0] ch;
        begin
            ch = 8'h00;
            if (pos < 5'(TYPE_STR_LEN) && idx < 3'(TYPE_PATS))
                ch = TYPE_STR[idx][8*(TYPE_STR_LEN-1-int'(pos)) +: 8];
            return ch;
        end
    endfunction

    function automatic logic [7:0] mark_pat_char(input logic [1:0] idx, input logic [3:0] pos);
        logic [7:0] ch;
        begin
            ch = 8'h00;
            if (pos < 4'(MARK_STR_LEN) && idx < 2'(MARK_PATS))
                ch = MARK_STR[idx][8*(MARK_STR_LEN-1-int'(pos)) +: 8];
            return ch;
        end
    endfunction

endpackage

>>> hdl/cts_type.sv
module cts_type
    import cts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_step       i_ctl,
    output t_type_class o_type_class
);

    logic                 r_lead_done, n_lead_done;
    logic                 r_cut, n_cut;
    logic [4:0]           r_len, n_len;
    logic [4:0]           r_pb, n_pb;
    logic [TYPE_PATS-1:0] r_flags, n_flags;
    logic [39:0]          r_win, n_win;

    logic [7:0] lc;
    logic [5:0] sum;
    logic [4:0] q;

    assign lc  = lower8(i_ctl.char_in);
    assign sum = {1'b0, r_len} + {1'b0, r_pb};
    assign q   = (sum > 6'd31) ? 5'd31 : sum[4:0];

    always_comb begin
        n_lead_done = r_lead_done;
        n_cut       = r_cut;
        n_len       = r_len;
        n_pb        = r_pb;
        n_flags     = r_flags;
        n_win       = r_win;
        if (i_ctl.step && !r_cut) begin
            if (i_ctl.char_in == 8'h3B || i_ctl.char_in == 8'h00) begin
                n_cut = 1'b1;
            end else if (i_ctl.char_in inside {8'h20, 8'h09}) begin
                if (r_lead_done && r_pb != 5'd31) n_pb = r_pb + 5'd1;
            end else begin
                n_lead_done = 1'b1;
                n_pb        = 5'd0;
                n_len       = (q == 5'd31) ? 5'd31 : q + 5'd1;
                // pending blanks never match a pattern byte, so they only
                // spare patterns already passed that allow a tail
                for (int i = 0; i < TYPE_PATS; i++) begin
                    if (!(r_pb == 5'd0 || (!TYPE_EXACT[i] && r_len >= TYPE_LEN[i])))
                        n_flags[i] = 1'b0;
                    if (q < TYPE_LEN[i]) begin
                        if (lc != type_pat_char(3'(i), q)) n_flags[i] = 1'b0;
                    end else if (TYPE_EXACT[i]) begin
                        n_flags[i] = 1'b0;
                    end
                end
                case (r_pb)
                    5'd0:    n_win = {r_win[31:0], lc};
                    5'd1:    n_win = {r_win[23:0], 8'h20, lc};
                    5'd2:    n_win = {r_win[15:0], 16'h2020, lc};
                    5'd3:    n_win = {r_win[7:0], 24'h202020, lc};
                    default: n_win = {32'h20202020, lc};
                endcase
            end
        end
        if (i_ctl.clear) begin
            n_lead_done = 1'b0;
            n_cut       = 1'b0;
            n_len       = 5'd0;
            n_pb        = 5'd0;
            n_flags     = '1;
            n_win       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_done <= 1'b0;
            r_cut       <= 1'b0;
            r_len       <= 5'd0;
            r_pb        <= 5'd0;
            r_flags     <= '1;
            r_win       <= '0;
        end else begin
            r_lead_done <= n_lead_done;
            r_cut       <= n_cut;
            r_len       <= n_len;
            r_pb        <= n_pb;
            r_flags     <= n_flags;
            r_win       <= n_win;
        end
    end

    always_comb begin
        o_type_class = CLS_UNSUP;
        if ((r_flags[0] && r_len == 5'd9) || (r_flags[1] && r_len == 5'd21)) begin
            o_type_class = CLS_HTML;
        end else if (r_flags[2] && r_len > 5'd5) begin
            o_type_class = CLS_TEXT;
        end else if (r_flags[3] && r_len > 5'd12) begin
            if ((r_flags[4] && r_len == 5'd16) || (r_flags[5] && r_len == 5'd15) ||
                (r_len > 5'd17 && r_win == SUFFIX_JSON) ||
                (r_len > 5'd16 && r_win[31:0] == SUFFIX_XML))
                o_type_class = CLS_TEXT;
        end
    end

endmodule

>>> hdl/cts_body.sv
module cts_body
    import cts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_step       i_ctl,
    input  t_expect     i_expected,
    input  t_type_class i_type_class,
    output logic        o_match
);

    logic                 r_nonempty, n_nonempty;
    logic                 r_started, n_started;
    logic [7:0]           r_first, n_first;
    logic [3:0]           r_pos, n_pos;
    logic [MARK_PATS-1:0] r_mflags, n_mflags;
    logic                 r_zero, n_zero;

    logic [7:0] lc;
    logic       rej;
    logic       json_ok;

    assign lc = lower8(i_ctl.char_in);

    always_comb begin
        n_nonempty = r_nonempty;
        n_started  = r_started;
        n_first    = r_first;
        n_pos      = r_pos;
        n_mflags   = r_mflags;
        n_zero     = r_zero;
        if (i_ctl.step) begin
            n_nonempty = 1'b1;
            if (i_ctl.char_in == 8'h00) n_zero = 1'b1;
            if (!r_started && !(i_ctl.char_in inside {8'h20, 8'h09, 8'h0D, 8'h0A})) begin
                n_started = 1'b1;
                n_first   = i_ctl.char_in;
            end
            if (n_started) begin
                for (int i = 0; i < MARK_PATS; i++) begin
                    if (r_pos < MARK_LEN[i] && lc != mark_pat_char(2'(i), r_pos))
                        n_mflags[i] = 1'b0;
                end
                if (r_pos != 4'd15) n_pos = r_pos + 4'd1;
            end
        end
    end

    // verdict on the state including this beat's byte
    always_comb begin
        json_ok = (n_first inside {8'h7B, 8'h5B, 8'h22, 8'h2D, 8'h74, 8'h66, 8'h6E}) ||
                  (n_first >= 8'h30 && n_first <= 8'h39);
        rej = (n_first == 8'h7B) || (n_first == 8'h5B);
        for (int i = 0; i < MARK_PATS; i++) begin
            if (n_mflags[i] && n_pos >= MARK_LEN[i]) rej = 1'b1;
        end
        if (i_expected == EXP_ANY)
            o_match = 1'b1;
        else if (i_type_class == CLS_HTML || !n_nonempty || !n_started)
            o_match = 1'b0;
        else if (i_expected == EXP_JSON)
            o_match = json_ok && !n_zero;
        else if (i_expected != EXP_ARCHIVE || i_type_class == CLS_TEXT)
            o_match = 1'b0;
        else
            o_match = !rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_nonempty <= 1'b0;
            r_started  <= 1'b0;
            r_first    <= 8'h00;
            r_pos      <= 4'd0;
            r_mflags   <= '1;
            r_zero     <= 1'b0;
        end else begin
            r_nonempty <= n_nonempty;
            r_started  <= n_started;
            r_first    <= n_first;
            r_pos      <= n_pos;
            r_mflags   <= n_mflags;
            r_zero     <= n_zero;
        end
    end

endmodule

>>> hdl/content_type_body_sniffer.sv
// media-type and body-prefix sniffer
// input channel: i_in_valid / o_in_stall with one beat per byte. a request
// sends its media-type bytes (i_func = 0), then its body-prefix bytes
// (i_func = 1); i_no_byte marks a beat that only closes an empty part, and
// i_part_end on a body beat closes the request and yields one result.
// output channel: o_out_valid / i_out_stall carrying o_matches_res and
// o_type_class; beats other than the body end produce nothing.
// throughput: one beat per cycle, sustained, unless a body end beat is held
// by a stalled full result register; the state update of the type and body
// matchers lies between the input register and the result register.
// path: a body end beat goes from the input register through the matchers
// into the result register, which then holds its result.
// stall: while the result register is full and stalled, a body end beat
// waits in the input register and the input stalls; other beats keep
// flowing since they need no result slot.
// reset (synchronous, active low) empties both registers and returns all
// matcher state to its idle values; the state also clears after each result.
`include "content_type_body_sniffer_macros.svh"

module content_type_body_sniffer
    import cts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_func,
    input  logic [7:0] i_char_in,
    input  logic       i_no_byte,
    input  logic       i_part_end,
    input  logic [1:0] i_expected,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_matches_res,
    output logic [1:0] o_type_class
);

    logic        r_iv;
    logic        r_func;
    logic [7:0]  r_char;
    logic        r_nob;
    logic        r_pend;
    t_expect     r_exp;

    logic        r_ov;
    logic        r_match;
    t_type_class r_cls;

    logic        s1_emit;
    logic        s1_go;
    t_step       type_ctl;
    t_step       body_ctl;
    t_type_class cls;
    logic        match;

    assign s1_emit    = r_func && r_pend;
    assign s1_go      = r_iv && (!s1_emit || !r_ov || !i_out_stall);
    assign o_in_stall = r_iv && !s1_go;

    assign type_ctl.step    = s1_go && !r_func && !r_nob;
    assign type_ctl.clear   = s1_go && s1_emit;
    assign type_ctl.char_in = r_char;
    assign body_ctl.step    = s1_go && r_func && !r_nob;
    assign body_ctl.clear   = s1_go && s1_emit;
    assign body_ctl.char_in = r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (!o_in_stall) begin
            r_iv <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_func <= i_func;
            r_char <= i_char_in;
            r_nob  <= i_no_byte;
            r_pend <= i_part_end;
            r_exp  <= t_expect'(i_expected);
        end
    end

    cts_type u_type (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (type_ctl),
        .o_type_class (cls)
    );

    cts_body u_body (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (body_ctl),
        .i_expected   (r_exp),
        .i_type_class (cls),
        .o_match      (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s1_go && s1_emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emit) begin
            r_match <= match;
            r_cls   <= cls;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_matches_res = r_match;
    assign o_type_class  = r_cls;

    `CTS_ASSERT_NOW(a_idle_no_stall, !r_iv, !o_in_stall, "input stalled with empty input register")
    `CTS_ASSERT_NEXT(a_any_matches, s1_go && s1_emit && r_exp == EXP_ANY,
        o_out_valid && o_matches_res, "expected any did not match")
    `CTS_ASSERT_NEXT(a_html_rejects, s1_go && s1_emit && r_exp != EXP_ANY && cls == CLS_HTML,
        o_out_valid && !o_matches_res, "html type matched a specific kind")
    `CTS_ASSERT_NEXT(a_clear_after_result, s1_go && s1_emit, cls == CLS_UNSUP,
        "type state not cleared after result")

endmodule
